// File: rtl/core/mslr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mslr_pkg;

   // number format and field widths
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int VALUE_WIDTH       = 32;
   localparam int BIAS_WIDTH        = 18;
   localparam int MODE_WIDTH        = 2;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = BIAS_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BIAS_WEIGHT  = 1'b0,
      CSR_LIMITER_MODE = 1'b1
   } csr_index_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      LIMITER_SUPER_BEE = 2'd0,
      LIMITER_VAN_LEER  = 2'd1,
      LIMITER_MIN_BEE   = 2'd2
   } limiter_mode_type;

endpackage

`default_nettype wire

// File: rtl/core/mslr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mslr_req_if import mslr_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [VALUE_WIDTH-1:0]  left_value;
   logic signed [VALUE_WIDTH-1:0]  middle_value;
   logic signed [VALUE_WIDTH-1:0]  right_value;

   modport source (output valid, output left_value, output middle_value,
                   output right_value, input ready);
   modport sink   (input valid, input left_value, input middle_value,
                   input right_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mslr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mslr_rsp_if import mslr_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [VALUE_WIDTH-1:0]  limited_slope;

   modport source (output valid, output limited_slope, input ready);
   modport sink   (input valid, input limited_slope, output ready);
endinterface

`default_nettype wire

// File: rtl/core/muscl_slope_limiter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | handshake        | payload
// ----------+-----+------------------+-----------------------------------------------
// req_if    | in  | valid / ready    | left_value, middle_value, right_value (s32)
// rsp_if    | out | valid / ready    | limited_slope (s32, saturated)
// csr_*     | in  | csr_write_enable | csr_index, csr_write_data (no read-back)
//
// one transaction per cycle in, one per cycle out while the output is taken (Q16.16
// by default); the pipe holds the 31-step steepness divider and the FRAC_BITS + 1 step
// xi and van-leer dividers that run side by side
// reset clears the valid bits and the configuration registers (bias 0, super-bee)
// one stall enable moves every stage: when the output register holds a transaction
// that is not taken, the whole pipe and req_if.ready freeze, nothing is lost

module muscl_slope_limiter_core
   import mslr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   mslr_req_if.sink                   req_if,
   mslr_rsp_if.source                 rsp_if,
   input  wire                        csr_write_enable,
   input  wire [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [CSR_DATA_WIDTH-1:0]   csr_write_data
);

   // widths derived from the fraction size
   localparam int DW   = VALUE_WIDTH + 1;                          // differences
   localparam int WW   = FRAC_BITS + 2;                            // wl, wr in 0..2*one
   localparam int BW   = ((BIAS_WIDTH > WW) ? BIAS_WIDTH : WW) + 1;// bias clamp
   localparam int PW   = WW + 1 + DW;                              // weight times diff
   localparam int SW   = DW + 1;                                   // biased slope
   localparam int RQ   = VALUE_WIDTH - 1;                          // steepness bits
   localparam int RSH  = RQ - FRAC_BITS;                           // dividend pre-shift
   localparam int XQ   = FRAC_BITS + 1;                            // xi / van-leer bits
   localparam int MW   = WW + RQ;                                  // wl times r
   localparam int XDW  = MW - FRAC_BITS + 1;                       // xi denominator
   localparam int VDW  = RQ + 1;                                   // one + r
   localparam int CW   = VALUE_WIDTH;                              // limiter compare
   localparam int PHW  = FRAC_BITS + 2;                            // phi in 0..2*one
   localparam int FW   = SW + PHW + 1;                             // slope times phi
   localparam int RW   = FW + 1;                                   // rounded product

   localparam logic signed [BW-1:0]  ONE_B     = BW'(1) << FRAC_BITS;
   localparam logic signed [PW:0]    ONE_P     = (PW + 1)'(1) << FRAC_BITS;
   localparam logic [XDW-1:0]        ONE_X     = XDW'(1) << FRAC_BITS;
   localparam logic [VDW-1:0]        ONE_V     = VDW'(1) << FRAC_BITS;
   localparam logic [CW-1:0]         ONE_C     = CW'(1) << FRAC_BITS;
   localparam logic [CW-1:0]         HALF_C    = CW'(1) << (FRAC_BITS - 1);
   localparam logic [CW-1:0]         TWO_C     = CW'(1) << (FRAC_BITS + 1);
   localparam logic signed [RW-1:0]  HALF_R    = RW'(1) << (FRAC_BITS - 1);
   localparam logic signed [RW-1:0]  RES_MAX   = RW'(32'h7FFF_FFFF);
   localparam logic signed [RW-1:0]  RES_MIN   = ~RES_MAX;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic signed [BIAS_WIDTH-1:0] bias_ff;
   logic [MODE_WIDTH-1:0]        mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
         mode_ff <= LIMITER_SUPER_BEE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BIAS_WEIGHT:  bias_ff <= csr_write_data;
            CSR_LIMITER_MODE: mode_ff <= csr_write_data[MODE_WIDTH-1:0];
            default:          ;
         endcase
      end
   end

   // bias clamped to +-one, then the two weights 1+b and 1-b
   logic signed [BW-1:0] bias_ext;
   logic signed [BW-1:0] bias_clamp;
   logic [WW-1:0]        wl;
   logic [WW-1:0]        wr;

   always_comb begin
      bias_ext = BW'(bias_ff);
      if (bias_ext > ONE_B) begin
         bias_clamp = ONE_B;
      end else if (bias_ext < -ONE_B) begin
         bias_clamp = -ONE_B;
      end else begin
         bias_clamp = bias_ext;
      end
      wl = WW'(ONE_B + bias_clamp);
      wr = WW'(ONE_B - bias_clamp);
   end

   // global stall: every stage moves when the output register can move
   logic advance;
   logic out_vld_ff;

   assign advance      = !out_vld_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // ------------------------------------------------------------------
   // stage 1: left and right differences
   // ------------------------------------------------------------------
   logic                 s1_vld_ff;
   logic signed [DW-1:0] dl_ff;
   logic signed [DW-1:0] dr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dl_ff <= DW'(req_if.middle_value) - DW'(req_if.left_value);
         dr_ff <= DW'(req_if.right_value) - DW'(req_if.middle_value);
      end
   end

   // ------------------------------------------------------------------
   // stage 2: magnitudes, zero difference as one lsb, weighted products,
   // steepness overflow test and divider setup
   // ------------------------------------------------------------------
   logic [DW-1:0]        num_mag_in;
   logic [DW-1:0]        den_mag_in;

   always_comb begin
      if (dl_ff == '0) begin
         num_mag_in = DW'(1);
      end else if (dl_ff < 0) begin
         num_mag_in = DW'(-dl_ff);
      end else begin
         num_mag_in = DW'(dl_ff);
      end
      if (dr_ff == '0) begin
         den_mag_in = DW'(1);
      end else if (dr_ff < 0) begin
         den_mag_in = DW'(-dr_ff);
      end else begin
         den_mag_in = DW'(dr_ff);
      end
   end

   logic                 rv_ff   [0:RQ];
   logic [DW-1:0]        rrem_ff [0:RQ];
   logic [DW-1:0]        rden_ff [0:RQ];
   logic [RQ-1:0]        rsh_ff  [0:RQ];
   logic                 rovf_ff [0:RQ];
   logic                 rneg_ff [0:RQ];
   logic signed [SW-1:0] rs_ff   [1:RQ];
   logic signed [PW-1:0] pl_ff;
   logic signed [PW-1:0] pr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else if (advance) begin
         rv_ff[0] <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pl_ff      <= $signed({1'b0, wl}) * dl_ff;
         pr_ff      <= $signed({1'b0, wr}) * dr_ff;
         // quotient reaches 2^31 when num >= den * 2^(31 - frac)
         rovf_ff[0] <= {RSH'(0), num_mag_in} >= {den_mag_in, RSH'(0)};
         rneg_ff[0] <= (dl_ff < 0) != (dr_ff < 0);
         rrem_ff[0] <= num_mag_in >> RSH;
         rden_ff[0] <= den_mag_in;
         rsh_ff[0]  <= {num_mag_in[RSH-1:0], FRAC_BITS'(0)};
      end
   end

   // ------------------------------------------------------------------
   // steepness divider: one restoring step per stage, dividend bits shift
   // out of the top of rsh while quotient bits shift in at the bottom
   // ------------------------------------------------------------------
   for (genvar k = 1; k <= RQ; k++) begin : g_rdiv
      logic [DW:0]   trial_in;
      logic          qbit_in;
      logic [DW-1:0] rem_in;

      always_comb begin
         trial_in = {rrem_ff[k-1], rsh_ff[k-1][RQ-1]} - {1'b0, rden_ff[k-1]};
         qbit_in  = !trial_in[DW];
         rem_in   = qbit_in ? trial_in[DW-1:0]
                            : {rrem_ff[k-1][DW-2:0], rsh_ff[k-1][RQ-1]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k] <= 1'b0;
         end else if (advance) begin
            rv_ff[k] <= rv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rrem_ff[k] <= rem_in;
            rden_ff[k] <= rden_ff[k-1];
            rsh_ff[k]  <= {rsh_ff[k-1][RQ-2:0], qbit_in};
            rovf_ff[k] <= rovf_ff[k-1];
            rneg_ff[k] <= rneg_ff[k-1];
         end
      end

      if (k == 1) begin : g_slope
         // biased slope, round half up: floor((wl*dl + wr*dr + one) / 2one)
         logic signed [PW:0] sum_in;
         logic signed [PW:0] shr_in;

         always_comb begin
            sum_in = (PW + 1)'(pl_ff) + (PW + 1)'(pr_ff) + ONE_P;
            shr_in = sum_in >>> (FRAC_BITS + 1);
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rs_ff[k] <= SW'(shr_in);
            end
         end
      end else begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rs_ff[k] <= rs_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage m: saturate steepness, product wl * r
   // ------------------------------------------------------------------
   logic [RQ-1:0]        r_in;
   logic                 m_vld_ff;
   logic [MW-1:0]        mprod_ff;
   logic [RQ-1:0]        mr_ff;
   logic signed [SW-1:0] ms_ff;
   logic                 mneg_ff;

   assign r_in = rovf_ff[RQ] ? {RQ{1'b1}} : rsh_ff[RQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (advance) begin
         m_vld_ff <= rv_ff[RQ];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mprod_ff <= MW'(wl) * MW'(r_in);
         mr_ff    <= r_in;
         ms_ff    <= rs_ff[RQ];
         mneg_ff  <= rneg_ff[RQ];
      end
   end

   // ------------------------------------------------------------------
   // stage d: xi denominator, divider setup for xi and van-leer
   // xi = 2one^2 / d is at least 2one whenever d <= one, so it is capped
   // there and the divider only needs frac + 1 quotient bits
   // ------------------------------------------------------------------
   logic [XDW-1:0] xd_in;

   assign xd_in = XDW'(wr) + XDW'(mprod_ff >> FRAC_BITS);

   logic                 xv_ff    [0:XQ];
   logic [XDW-1:0]       xrem_ff  [0:XQ];
   logic [XDW-1:0]       xden_ff  [0:XQ];
   logic [XQ-1:0]        xq_ff    [0:XQ];
   logic                 xbig_ff  [0:XQ];
   logic [VDW-1:0]       vrem_ff  [0:XQ];
   logic [VDW-1:0]       vden_ff  [0:XQ];
   logic [XQ-1:0]        vq_ff    [0:XQ];
   logic [RQ-1:0]        xr_ff    [0:XQ];
   logic signed [SW-1:0] xs_ff    [0:XQ];
   logic                 xneg_ff  [0:XQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         xv_ff[0] <= 1'b0;
      end else if (advance) begin
         xv_ff[0] <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xrem_ff[0] <= ONE_X;
         xden_ff[0] <= xd_in;
         xq_ff[0]   <= '0;
         xbig_ff[0] <= xd_in <= ONE_X;
         // van-leer core 2r*one / (one + r): dividend high part is r itself
         vrem_ff[0] <= VDW'(mr_ff);
         vden_ff[0] <= ONE_V + VDW'(mr_ff);
         vq_ff[0]   <= '0;
         xr_ff[0]   <= mr_ff;
         xs_ff[0]   <= ms_ff;
         xneg_ff[0] <= mneg_ff;
      end
   end

   // xi and van-leer dividers, side by side, dividend tails are all zero
   for (genvar k = 1; k <= XQ; k++) begin : g_xdiv
      logic [XDW:0]   xtrial_in;
      logic           xbit_in;
      logic [VDW:0]   vtrial_in;
      logic           vbit_in;

      always_comb begin
         xtrial_in = {xrem_ff[k-1], 1'b0} - {1'b0, xden_ff[k-1]};
         xbit_in   = !xtrial_in[XDW];
         vtrial_in = {vrem_ff[k-1], 1'b0} - {1'b0, vden_ff[k-1]};
         vbit_in   = !vtrial_in[VDW];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            xv_ff[k] <= 1'b0;
         end else if (advance) begin
            xv_ff[k] <= xv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            xrem_ff[k] <= xbit_in ? xtrial_in[XDW-1:0] : {xrem_ff[k-1][XDW-2:0], 1'b0};
            xden_ff[k] <= xden_ff[k-1];
            xq_ff[k]   <= {xq_ff[k-1][XQ-2:0], xbit_in};
            xbig_ff[k] <= xbig_ff[k-1];
            vrem_ff[k] <= vbit_in ? vtrial_in[VDW-1:0] : {vrem_ff[k-1][VDW-2:0], 1'b0};
            vden_ff[k] <= vden_ff[k-1];
            vq_ff[k]   <= {vq_ff[k-1][XQ-2:0], vbit_in};
            xr_ff[k]   <= xr_ff[k-1];
            xs_ff[k]   <= xs_ff[k-1];
            xneg_ff[k] <= xneg_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage phi: limiter select; opposite signs give a negative steepness
   // and phi of zero, a zero steepness gives zero in every limiter
   // ------------------------------------------------------------------
   logic [CW-1:0] r_c;
   logic [CW-1:0] xi_c;
   logic [CW-1:0] core_c;
   logic [CW-1:0] phi_in;

   always_comb begin
      r_c    = CW'(xr_ff[XQ]);
      xi_c   = xbig_ff[XQ] ? TWO_C : CW'(xq_ff[XQ]);
      core_c = CW'(vq_ff[XQ]);
      case (mode_ff)
         LIMITER_SUPER_BEE: begin
            if (r_c < HALF_C) begin
               phi_in = r_c << 1;
            end else if (r_c < ONE_C) begin
               phi_in = ONE_C;
            end else begin
               phi_in = (r_c < xi_c) ? r_c : xi_c;
            end
         end
         LIMITER_VAN_LEER: begin
            phi_in = (core_c < xi_c) ? core_c : xi_c;
         end
         default: begin
            // min-bee, also for the unused mode code
            if (r_c < ONE_C) begin
               phi_in = r_c;
            end else begin
               phi_in = (ONE_C < xi_c) ? ONE_C : xi_c;
            end
         end
      endcase
      if (xneg_ff[XQ]) begin
         phi_in = '0;
      end
      if (phi_in > TWO_C) begin
         phi_in = TWO_C;
      end
   end

   logic                 phi_vld_ff;
   logic [PHW-1:0]       phi_ff;
   logic signed [SW-1:0] phs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phi_vld_ff <= 1'b0;
      end else if (advance) begin
         phi_vld_ff <= xv_ff[XQ];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phi_ff <= PHW'(phi_in);
         phs_ff <= xs_ff[XQ];
      end
   end

   // ------------------------------------------------------------------
   // stage prod: slope times phi
   // ------------------------------------------------------------------
   logic                 prod_vld_ff;
   logic signed [FW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (advance) begin
         prod_vld_ff <= phi_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= phs_ff * $signed({1'b0, phi_ff});
      end
   end

   // ------------------------------------------------------------------
   // output register: round half up back to the fixed point grid, saturate
   // ------------------------------------------------------------------
   logic signed [RW-1:0]          rnd_in;
   logic signed [VALUE_WIDTH-1:0] res_in;
   logic signed [VALUE_WIDTH-1:0] res_ff;

   always_comb begin
      rnd_in = (RW'(prod_ff) + HALF_R) >>> FRAC_BITS;
      if (rnd_in > RES_MAX) begin
         res_in = VALUE_WIDTH'(RES_MAX);
      end else if (rnd_in < RES_MIN) begin
         res_in = VALUE_WIDTH'(RES_MIN);
      end else begin
         res_in = VALUE_WIDTH'(rnd_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_if.valid         = out_vld_ff;
   assign rsp_if.limited_slope = res_ff;

endmodule

`default_nettype wire

// File: rtl/core/mslr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mslr_checker
   import mslr_pkg::*;
(
   input wire                   clock,
   input wire                   reset,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire [VALUE_WIDTH-1:0] rsp_data
);

   // nothing comes out in the cycle after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty output register never blocks the input side
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a held result freezes the pipe, so no new transaction enters
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output stalled");

   // a stalled result stays and holds its value
   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

endmodule

bind muscl_slope_limiter_core mslr_checker u_mslr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.limited_slope)
);

`default_nettype wire

// File: test/muscl_slope_limiter_core_test.sv
`timescale 1ns / 1ps

module muscl_slope_limiter_core_test;
   import mslr_pkg::*;

   // q16.16 unit and the pipeline depth of the core
   localparam int unsigned FRAC = 16;
   localparam longint ONE_Q = 64'sd1 << FRAC;
   localparam longint XI_BIG = 64'sd1 << 62;
   localparam int PIPE_DEPTH = FRAC + 39;

   // one directed row: config, cell values, optional typed-in slope
   typedef struct {
      logic signed [BIAS_WIDTH-1:0] bias;
      logic [MODE_WIDTH-1:0] mode;
      logic signed [31:0] left_cell;
      logic signed [31:0] mid_cell;
      logic signed [31:0] right_cell;
      bit has_known;
      logic signed [31:0] known_slope;
   } slope_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   mslr_req_if req_if ();
   mslr_rsp_if rsp_if ();

   muscl_slope_limiter_core dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor copy of the configuration registers
   longint bias_reg = 0;
   logic [MODE_WIDTH-1:0] mode_reg = LIMITER_SUPER_BEE;

   logic signed [31:0] slope_queue[$];
   int mismatch_count = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   bit receiver_hold = 1'b0;

   slope_row_type rows[$];

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("muscl_slope_limiter_core regression: fail");
      $finish;
   end

   // floor division by 2^s
   function automatic longint floor_sh(longint x, int unsigned s);
      return x >>> s;
   endfunction

   function automatic longint xi_cap(longint r, longint wl, longint wr);
      longint d;
      d = wr + floor_sh(wl * r, FRAC);
      if (d <= 0) return XI_BIG;
      return (64'sd1 << (2 * FRAC + 1)) / d;
   endfunction

   function automatic longint min2(longint a, longint b);
      return a < b ? a : b;
   endfunction

   function automatic logic signed [31:0] predict_slope(logic signed [31:0] lv,
         logic signed [31:0] mv, logic signed [31:0] rv);
      longint dl, dr, b, wl, wr, nm, dn, q, r, s, phi, res;
      dl = longint'(mv) - longint'(lv);
      dr = longint'(rv) - longint'(mv);
      b = bias_reg;
      if (b > ONE_Q) b = ONE_Q;
      if (b < -ONE_Q) b = -ONE_Q;
      wl = ONE_Q + b;
      wr = ONE_Q - b;
      // a flat difference counts as one lsb
      nm = (dl == 0) ? 1 : dl;
      dn = (dr == 0) ? 1 : dr;
      q = ((nm < 0 ? -nm : nm) << FRAC) / (dn < 0 ? -dn : dn);
      // a tiny negative steepness truncates to zero, not below
      if ((nm < 0) != (dn < 0)) r = (q > 64'sh80000000) ? -64'sh80000000 : -q;
      else r = (q > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : q;
      s = floor_sh(wl * dl + wr * dr + ONE_Q, FRAC + 1);
      if (r < 0) phi = 0;
      else if (mode_reg == LIMITER_SUPER_BEE) begin
         if (r < ONE_Q / 2) phi = 2 * r;
         else if (r < ONE_Q) phi = ONE_Q;
         else phi = min2(min2(r, xi_cap(r, wl, wr)), 2 * ONE_Q);
      end else if (mode_reg == LIMITER_VAN_LEER) begin
         phi = min2(((r * 2) << FRAC) / (ONE_Q + r), xi_cap(r, wl, wr));
      end else begin
         // mode three falls through to min-bee
         if (r < ONE_Q) phi = r;
         else phi = min2(ONE_Q, xi_cap(r, wl, wr));
      end
      if (phi > 2 * ONE_Q) phi = 2 * ONE_Q;
      res = floor_sh(s * phi + ONE_Q / 2, FRAC);
      if (res > 64'sh7FFFFFFF) res = 64'sh7FFFFFFF;
      if (res < -64'sh80000000) res = -64'sh80000000;
      return res[31:0];
   endfunction

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_BIAS_WEIGHT) bias_reg = longint'($signed(data));
      else mode_reg = data[MODE_WIDTH-1:0];
   endtask

   // stop offering and wait for the pipe to drain before touching the registers
   task automatic drain_pipe();
      req_if.valid <= 1'b0;
      while (slope_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic set_config(logic signed [BIAS_WIDTH-1:0] bias, logic [MODE_WIDTH-1:0] mode);
      if (longint'(bias) != bias_reg) write_csr(CSR_BIAS_WEIGHT, bias);
      if (mode != mode_reg) write_csr(CSR_LIMITER_MODE, CSR_DATA_WIDTH'(mode));
   endtask

   // offer one transaction, with random idle before it, until accepted
   task automatic send_cells(logic signed [31:0] lv, logic signed [31:0] mv,
         logic signed [31:0] rv, bit has_known, logic signed [31:0] known);
      logic signed [31:0] want;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.left_value <= lv;
      req_if.middle_value <= mv;
      req_if.right_value <= rv;
      want = has_known ? known : predict_slope(lv, mv, rv);
      do @(posedge clock); while (!req_if.ready);
      slope_queue.push_back(want);
   endtask

   function automatic logic signed [31:0] rand_cell();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(400000)) - 200000;
         2: return $signed($urandom_range(2000)) - 1000;
         default: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      endcase
   endfunction

   // mostly smooth neighbors, some fully random, so all steepness regions and both signs are hit
   task automatic send_random();
      logic signed [31:0] m, a, c;
      int sc;
      m = rand_cell();
      if ($urandom_range(3) == 0) begin
         a = rand_cell();
         c = rand_cell();
      end else begin
         sc = $urandom_range(5) * 4;
         a = m - ($signed($urandom) >>> sc);
         c = m + ($signed($urandom) >>> sc);
         if ($urandom_range(9) == 0) a = m;
         if ($urandom_range(9) == 0) c = m;
      end
      send_cells(a, m, c, 1'b0, '0);
   endtask

   task automatic add_row(logic signed [BIAS_WIDTH-1:0] bias, logic [MODE_WIDTH-1:0] mode,
         logic signed [31:0] lv, logic signed [31:0] mv, logic signed [31:0] rv,
         bit has_known, logic signed [31:0] known);
      slope_row_type row;
      row.bias = bias;
      row.mode = mode;
      row.left_cell = lv;
      row.mid_cell = mv;
      row.right_cell = rv;
      row.has_known = has_known;
      row.known_slope = known;
      rows.push_back(row);
   endtask

   // result side: random stalls, field compare against oldest expectation
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= !receiver_hold && ($urandom_range(99) >= receiver_idle_pct);
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (slope_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected slope transaction %0d", rsp_if.limited_slope);
            end else begin
               logic signed [31:0] want;
               want = slope_queue.pop_front();
               if (rsp_if.limited_slope !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("limited_slope mismatch: expected %0d got %0d",
                              want, rsp_if.limited_slope);
               end
            end
         end
      end
   end

   localparam logic signed [BIAS_WIDTH-1:0] B_PLUS = 18'sd65536;
   localparam logic signed [BIAS_WIDTH-1:0] B_MINUS = -18'sd65536;
   localparam logic signed [BIAS_WIDTH-1:0] B_OVER = 18'sh1FFFF;
   localparam logic signed [BIAS_WIDTH-1:0] B_UNDER = 18'sh20000;
   localparam logic [MODE_WIDTH-1:0] MODE_THREE = 2'd3;

   initial begin
      req_if.valid <= 1'b0;
      req_if.left_value <= '0;
      req_if.middle_value <= '0;
      req_if.right_value <= '0;

      // directed table: all flat gives zero slope, opposite signs give zero
      add_row(18'sd0, LIMITER_SUPER_BEE, 0, 0, 0, 1'b1, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 0, 65536, 0, 1'b1, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 0, 65536, 131072, 1'b1, 65536);
      add_row(18'sd0, LIMITER_SUPER_BEE, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
              1'b1, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 32'sh80000000, 0, 32'sh7FFFFFFF, 1'b0, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 32'sh7FFFFFFF, 0, 32'sh80000000, 1'b0, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 0, 100, 400, 1'b0, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 0, 1, -100000000, 1'b0, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 0, 0, 5, 1'b0, 0);
      add_row(18'sd0, LIMITER_SUPER_BEE, 0, 5, 5, 1'b0, 0);
      add_row(18'sd0, LIMITER_VAN_LEER, 0, 300, 400, 1'b0, 0);
      add_row(18'sd0, LIMITER_VAN_LEER, 0, 1000, 1001, 1'b0, 0);
      add_row(18'sd0, LIMITER_MIN_BEE, 0, 300, 400, 1'b0, 0);
      add_row(18'sd0, LIMITER_MIN_BEE, 0, 900, 1000, 1'b0, 0);
      add_row(18'sd0, MODE_THREE, 0, 900, 1000, 1'b0, 0);
      // bias +1 with a flat left side: vanishing xi denominator
      add_row(B_PLUS, LIMITER_SUPER_BEE, 0, 0, 500, 1'b0, 0);
      add_row(B_PLUS, LIMITER_VAN_LEER, 0, 70000, 70000, 1'b0, 0);
      add_row(B_PLUS, LIMITER_MIN_BEE, 0, 900, 100, 1'b0, 0);
      add_row(B_MINUS, LIMITER_SUPER_BEE, 0, 900, 100, 1'b0, 0);
      add_row(B_OVER, LIMITER_VAN_LEER, 0, 900, 100, 1'b0, 0);
      add_row(B_UNDER, LIMITER_MIN_BEE, 0, 900, 100, 1'b0, 0);
      add_row(B_OVER, LIMITER_SUPER_BEE, 32'sh80000000, 0, 32'sh7FFFFFFF, 1'b0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].bias != bias_reg[BIAS_WIDTH-1:0] || rows[i].mode != mode_reg) begin
            drain_pipe();
            set_config(rows[i].bias, rows[i].mode);
         end
         send_cells(rows[i].left_cell, rows[i].mid_cell, rows[i].right_cell,
                    rows[i].has_known, rows[i].known_slope);
      end

      // back-pressure: hold the receiver while the sender keeps offering
      drain_pipe();
      set_config(18'sd20000, LIMITER_VAN_LEER);
      fork
         begin
            receiver_hold = 1'b1;
            repeat (PIPE_DEPTH * 3) @(posedge clock);
            receiver_hold = 1'b0;
         end
         repeat (120) send_random();
      join

      // random phases over several settings; both sides idle at random in the first six, neither in the last three
      for (int ph = 0; ph < 9; ph++) begin
         drain_pipe();
         case (ph)
            0: set_config(18'sd0, LIMITER_SUPER_BEE);
            1: set_config(B_PLUS, LIMITER_VAN_LEER);
            2: set_config(B_MINUS, LIMITER_MIN_BEE);
            3: set_config(B_OVER, MODE_THREE);
            4: set_config(B_UNDER, LIMITER_SUPER_BEE);
            default: set_config(BIAS_WIDTH'($signed($urandom_range(131072)) - 65536),
                                MODE_WIDTH'($urandom_range(3)));
         endcase
         sender_idle_pct = (ph < 3) ? 34 : (ph < 6) ? 49 : 0;
         receiver_idle_pct = (ph < 3) ? 49 : (ph < 6) ? 34 : 0;
         repeat (90) send_random();
      end

      req_if.valid <= 1'b0;
      while (slope_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (mismatch_count == 0 && slope_queue.size() == 0)
         $display("muscl_slope_limiter_core regression: pass");
      else
         $display("muscl_slope_limiter_core regression: fail");
      $finish;
   end

endmodule
